FILE: src/kss_pkg.sv
package kss_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int ID_W           = 16;
    localparam int INC_W          = 16;
    localparam int SCORE_W        = 8;
    localparam int IDX_OUT_W      = 3;
    localparam int SUM_W          = INC_W + 1;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
    localparam logic [ID_W-1:0]    ID_EMPTY  = '0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DONE
    } scan_state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef struct packed {
        logic                 at_maximum;
        logic [SCORE_W-1:0]   new_score;
        logic [IDX_OUT_W-1:0] slot_index;
        logic                 recorded;
    } result_t;

endpackage

FILE: src/kss_slot_mem.sv
module kss_slot_mem #(
    parameter int SLOT_COUNT = kss_pkg::SLOT_COUNT_DEF,
    parameter int IDX_W      = 3
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  kss_pkg::mem_ctl_t           ctl,
    input  logic [IDX_W-1:0]            rd_addr,
    input  logic [IDX_W-1:0]            wr_addr,
    input  logic [kss_pkg::ID_W-1:0]    wr_id,
    input  logic [kss_pkg::SCORE_W-1:0] wr_score,
    output logic [kss_pkg::ID_W-1:0]    rd_id,
    output logic [kss_pkg::SCORE_W-1:0] rd_score
);
    import kss_pkg::*;

    logic [ID_W-1:0]    mem_id    [SLOT_COUNT];
    logic [SCORE_W-1:0] mem_score [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_reg;

    logic [ID_W-1:0]    rd_id_reg;
    logic [SCORE_W-1:0] rd_score_reg;
    logic               rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem_id[wr_addr]    <= wr_id;
            mem_score[wr_addr] <= wr_score;
        end
        if (ctl.rd_en) begin
            rd_id_reg    <= mem_id[rd_addr];
            rd_score_reg <= mem_score[rd_addr];
        end
    end

    // never-written entries read as an empty slot with zero score
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (ctl.wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_id    = rd_valid_reg ? rd_id_reg    : ID_EMPTY;
    assign rd_score = rd_valid_reg ? rd_score_reg : '0;

endmodule

FILE: src/kss_scan_ctrl.sv
module kss_scan_ctrl #(
    parameter int SLOT_COUNT = kss_pkg::SLOT_COUNT_DEF,
    parameter int IDX_W      = 3
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [kss_pkg::ID_W-1:0]    in_id,
    input  logic [kss_pkg::INC_W-1:0]   in_inc,
    output kss_pkg::mem_ctl_t           mem_ctl,
    output logic [IDX_W-1:0]            rd_addr,
    output logic [IDX_W-1:0]            wr_addr,
    output logic [kss_pkg::ID_W-1:0]    wr_id,
    output logic [kss_pkg::SCORE_W-1:0] wr_score,
    input  logic [kss_pkg::ID_W-1:0]    rd_id,
    input  logic [kss_pkg::SCORE_W-1:0] rd_score,
    output logic                        res_valid,
    input  logic                        res_ready,
    output kss_pkg::result_t            res
);
    import kss_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    scan_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [ID_W-1:0]    id_reg;
    logic [INC_W-1:0]   inc_reg;
    result_t            res_reg;

    logic                 accept;
    logic                 hit;
    logic                 last;
    logic [SUM_W-1:0]     sum;
    logic [SCORE_W-1:0]   sat;
    logic [IDX_W+2:0]     idx_ext;

    assign accept  = in_valid && in_ready;
    // empty slot or own id ends the scan
    assign hit     = (rd_id == ID_EMPTY) || (rd_id == id_reg);
    assign last    = (idx_reg == LAST_IDX);
    assign sum     = SUM_W'(rd_score) + SUM_W'(inc_reg);
    assign sat     = (sum >= SUM_W'(SCORE_MAX)) ? SCORE_MAX : sum[SCORE_W-1:0];
    assign idx_ext = {3'b000, idx_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_CHECK;
            ST_CHECK: if (hit || last) state_next = ST_DONE;
            ST_DONE:  if (res_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready      = 1'b0;
        mem_ctl.rd_en = 1'b0;
        mem_ctl.wr_en = 1'b0;
        rd_addr       = '0;
        res_valid     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready      = 1'b1;
                mem_ctl.rd_en = accept;
            end
            ST_CHECK: begin
                mem_ctl.wr_en = hit;
                mem_ctl.rd_en = !hit && !last;
                rd_addr       = idx_reg + 1'b1;
            end
            ST_DONE: begin
                res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign wr_addr  = idx_reg;
    assign wr_id    = id_reg;
    assign wr_score = sat;
    assign res      = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            id_reg  <= in_id;
            inc_reg <= in_inc;
            idx_reg <= '0;
        end else if (state_reg == ST_CHECK) begin
            if (hit) begin
                res_reg.recorded   <= 1'b1;
                res_reg.slot_index <= idx_ext[IDX_OUT_W-1:0];
                res_reg.new_score  <= sat;
                res_reg.at_maximum <= (sat == SCORE_MAX);
            end else begin
                res_reg <= '0;
                if (!last) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

endmodule

FILE: src/keyed_saturating_score_table.sv
// Keyed saturating score table. Each input item credits score_increment to
// the slot holding the alert key, claiming the first empty slot (key 0) when
// the key is new; the score saturates at 255. The scan reads one slot per cycle
// from a single slot memory and stops at the first empty or matching slot. An
// item is not taken before the last one's scan is done and its result is
// taken; a scan reads 1 to SLOT_COUNT slots. The memory comes out of reset
// empty with no clearing pass. The result of a full table is recorded = 0
// with all other fields zero; an alert key of 0 credits the first empty slot
// but leaves it empty. slot_index carries the low three bits of the slot
// number.
module keyed_saturating_score_table #(
    parameter int SLOT_COUNT = kss_pkg::SLOT_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] alert_key, [31:16] score_increment
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] recorded, [3:1] slot_index, [11:4] new_score, [12] at_maximum,
    // [15:13] zero
    output logic [15:0] m_tdata
);
    import kss_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    mem_ctl_t           mem_ctl;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [ID_W-1:0]    wr_id;
    logic [SCORE_W-1:0] wr_score;
    logic [ID_W-1:0]    rd_id;
    logic [SCORE_W-1:0] rd_score;
    logic               res_valid;
    logic               res_ready;
    result_t            res;

    // output register: lets a result wait while the next item is scanned
    logic               m_tvalid_reg;
    result_t            m_res_reg;

    kss_scan_ctrl #(
        .SLOT_COUNT(SLOT_COUNT),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_id    (s_tdata[15:0]),
        .in_inc   (s_tdata[31:16]),
        .mem_ctl  (mem_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_id    (wr_id),
        .wr_score (wr_score),
        .rd_id    (rd_id),
        .rd_score (rd_score),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    kss_slot_mem #(
        .SLOT_COUNT(SLOT_COUNT),
        .IDX_W     (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_id   (wr_id),
        .wr_score(wr_score),
        .rd_id   (rd_id),
        .rd_score(rd_score)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_res_reg};

endmodule

FILE: src/kss_checker.sv
module kss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one item in flight: the scan never takes a second item right away
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken during scan");

    // full table reports all fields zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> (m_tdata[12:1] == 12'd0))
        else $error("nonzero fields on full-table result");

    // maximum flag tracks the score
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[12] == (m_tdata[11:4] == 8'hFF)))
        else $error("at_maximum disagrees with new_score");

endmodule

bind keyed_saturating_score_table kss_checker u_kss_checker (.*);

FILE: dv/keyed_saturating_score_table_test.sv
module keyed_saturating_score_table_test;
    import kss_pkg::*;

    localparam int QUIET_LIMIT = 1000;  // cycles with no handshake before giving up
    localparam int RANDOM_ITEMS = 1750;
    localparam int CALM_TAIL = 150;     // last items run with no idling on either side
    localparam int DRAIN_CYCLES = SLOT_COUNT_DEF + 4;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [INC_W-1:0] inc;
        logic             typed;   // want holds a hand-written result
        result_t          want;
    } probe_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // Shadow copy of the slot table.
    logic [ID_W-1:0]    shadow_ids    [SLOT_COUNT_DEF];
    logic [SCORE_W-1:0] shadow_scores [SLOT_COUNT_DEF];

    result_t score_q [$];
    probe_t  probes [$];

    bit calm = 1'b0;
    int errors = 0;
    int n_sent = 0;
    int n_credited = 0;
    int n_full = 0;
    int n_ceiling = 0;
    int quiet_cycles = 0;
    int stall_left = 0;

    keyed_saturating_score_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Scan from slot 0, stop at the first empty or matching slot; an empty slot
    // takes the id (an id of 0 leaves it empty). Score saturates at the max.
    function automatic result_t credit_alert(input logic [ID_W-1:0] id,
                                             input logic [INC_W-1:0] inc);
        result_t         r;
        logic [SUM_W-1:0] sum;
        bit              hit;
        r = '0;
        hit = 1'b0;
        for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
            if (!hit) begin
                if (shadow_ids[i] == ID_EMPTY)
                    shadow_ids[i] = id;
                if (shadow_ids[i] == id) begin
                    sum = SUM_W'(shadow_scores[i]) + SUM_W'(inc);
                    if (sum >= SUM_W'(SCORE_MAX))
                        sum = SUM_W'(SCORE_MAX);
                    shadow_scores[i] = sum[SCORE_W-1:0];
                    r.recorded = 1'b1;
                    r.slot_index = IDX_OUT_W'(i);
                    r.new_score = sum[SCORE_W-1:0];
                    r.at_maximum = (sum[SCORE_W-1:0] == SCORE_MAX);
                    hit = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic add_probe(input logic [ID_W-1:0] id, input logic [INC_W-1:0] inc,
                             input logic typed, input logic rec, input logic [2:0] idx,
                             input logic [7:0] score, input logic at_max);
        probe_t p;
        p.id = id;
        p.inc = inc;
        p.typed = typed;
        p.want.recorded = rec;
        p.want.slot_index = idx;
        p.want.new_score = score;
        p.want.at_maximum = at_max;
        probes.push_back(p);
    endtask

    // Offer one item, hold it until taken, then queue what it should produce.
    // A random idle burst may follow unless the run is in its calm tail.
    task automatic offer_alert(input logic [ID_W-1:0] id, input logic [INC_W-1:0] inc,
                               input logic typed, input result_t want);
        result_t predicted;
        s_tvalid <= 1'b1;
        s_tdata <= {inc, id};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = credit_alert(id, inc);
        score_q.push_back(typed ? want : predicted);
        n_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (score_q.size() != 0)
            @(posedge aclk);
    endtask

    // Result side: random stall bursts, none in the calm tail.
    always @(posedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each taken result against the oldest expectation.
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[12:0];
            if (score_q.size() == 0) begin
                $display("%0t: unexpected item, m_tdata %h", $time, m_tdata);
                errors++;
            end else begin
                want = score_q.pop_front();
                if (got.recorded !== want.recorded) begin
                    $display("%0t: recorded expected %0d actual %0d",
                             $time, want.recorded, got.recorded);
                    errors++;
                end
                if (got.slot_index !== want.slot_index) begin
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, want.slot_index, got.slot_index);
                    errors++;
                end
                if (got.new_score !== want.new_score) begin
                    $display("%0t: new_score expected %0d actual %0d",
                             $time, want.new_score, got.new_score);
                    errors++;
                end
                if (got.at_maximum !== want.at_maximum) begin
                    $display("%0t: at_maximum expected %0d actual %0d",
                             $time, want.at_maximum, got.at_maximum);
                    errors++;
                end
                if (m_tdata[15:13] !== 3'b000) begin
                    $display("%0t: pad bits expected 0 actual %b", $time, m_tdata[15:13]);
                    errors++;
                end
                if (want.recorded) n_credited++;
                else n_full++;
                if (want.at_maximum) n_ceiling++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [ID_W-1:0]  id;
        logic [INC_W-1:0] inc;
        int               pick;

        for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
            shadow_ids[i] = ID_EMPTY;
            shadow_scores[i] = '0;
        end

        // id, increment, typed, recorded, index, score, at max
        add_probe(16'h0000, 16'd5,    1, 1, 3'd0, 8'd5,   0); // empty marker, slot stays empty
        add_probe(16'h0001, 16'd10,   0, 0, 3'd0, 8'd0,   0); // claim on leftover score
        add_probe(16'hFFFF, 16'hFFFF, 1, 1, 3'd1, 8'd255, 1); // all-ones extremes
        add_probe(16'hFFFF, 16'h0000, 1, 1, 3'd1, 8'd255, 1); // stays saturated
        add_probe(16'h8000, 16'd254,  0, 0, 3'd0, 8'd0,   0); // one below ceiling
        add_probe(16'h8000, 16'd1,    0, 0, 3'd0, 8'd0,   0); // lands exactly on ceiling
        add_probe(16'h0000, 16'h0000, 0, 0, 3'd0, 8'd0,   0); // marker on a fresh slot
        add_probe(16'h5555, 16'd2,    0, 0, 3'd0, 8'd0,   0);
        add_probe(16'hAAAA, 16'h0000, 0, 0, 3'd0, 8'd0,   0);
        add_probe(16'h1234, 16'd1,    0, 0, 3'd0, 8'd0,   0);
        add_probe(16'h0002, 16'h0100, 0, 0, 3'd0, 8'd0,   0); // low byte zero, must saturate
        add_probe(16'h00FF, 16'd3,    0, 0, 3'd0, 8'd0,   0); // last slot, table now full
        add_probe(16'hBEEF, 16'd1,    1, 0, 3'd0, 8'd0,   0); // full table
        add_probe(16'h0000, 16'd7,    1, 0, 3'd0, 8'd0,   0); // marker finds no empty slot
        add_probe(16'hFFFE, 16'hFFFF, 1, 0, 3'd0, 8'd0,   0);
        add_probe(16'h0001, 16'h0000, 0, 0, 3'd0, 8'd0,   0); // zero increment on resident
        add_probe(16'h00FF, 16'd100,  0, 0, 3'd0, 8'd0,   0); // deepest scan

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (probes[k])
            offer_alert(probes[k].id, probes[k].inc, probes[k].typed, probes[k].want);
        wait_drained();

        // Mostly credits to resident ids with small increments so that scores
        // climb slowly; the rest are unknown ids, markers and near-miss ids.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2)
                wait_drained();
            if (k == RANDOM_ITEMS - CALM_TAIL)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 75)
                id = shadow_ids[$urandom_range(0, SLOT_COUNT_DEF - 1)];
            else if (pick < 85)
                id = ID_W'($urandom_range(0, 65535));
            else if (pick < 90)
                id = ID_EMPTY;
            else
                id = shadow_ids[$urandom_range(0, SLOT_COUNT_DEF - 1)]
                     ^ (ID_W'(1) << $urandom_range(0, ID_W - 1));
            pick = $urandom_range(0, 99);
            if (pick < 60)
                inc = INC_W'($urandom_range(0, 1));
            else if (pick < 85)
                inc = INC_W'($urandom_range(0, 15));
            else if (pick < 95)
                inc = INC_W'($urandom_range(0, 255));
            else
                inc = INC_W'($urandom_range(0, 65535));
            offer_alert(id, inc, 1'b0, '0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        errors += score_q.size();

        $display("covered %0d alert items: %0d credited, %0d refused by a full table,",
                 n_sent, n_credited, n_full);
        $display("%0d results at the score ceiling", n_ceiling);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: keyed_saturating_score_table.f
src/kss_pkg.sv
src/kss_slot_mem.sv
src/kss_scan_ctrl.sv
src/keyed_saturating_score_table.sv
src/kss_checker.sv
dv/keyed_saturating_score_table_test.sv
